FILE: src/sto_pkg.sv
// Shared types, constants and quarter-wave table function for the sine tone oscillator.
`default_nettype none

package sto_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int AMPLITUDE_DEF       = 32767;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 15;
    localparam int STEP_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 2 * SAMPLE_W;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_PHASE_STEP = 2'd1
    } cfg_reg_t;

    // Per-item control carried alongside the table read
    typedef struct packed {
        logic mute;
        logic neg;
        logic last;
    } sto_ctl_t;

    // Quarter-wave magnitude scaled to amp, computed in Q30, evaluated at elaboration only
    function automatic logic [MAG_W-1:0] quarter_sine(int unsigned idx, int unsigned tab,
                                                      int unsigned amp);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned amp64;
        amp64 = 64'(amp);
        if (64'(idx) >= (64'd1 << tab))
            return MAG_W'(amp64);
        x  = (64'(idx) * HALF_PI_Q30) >> tab;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return MAG_W'((s * amp64) >> 30);
    endfunction

endpackage

`default_nettype wire

FILE: src/sto_phase.sv
// Phase accumulator and quarter-wave table address generation.
`default_nettype none

module sto_phase #(
    parameter int PHASE_BITS      = sto_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = sto_pkg::TABLE_ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic                         enable,
    input  wire logic [sto_pkg::STEP_W-1:0]   phase_step,
    input  wire logic                         end_of_buffer,
    output logic      [TABLE_ADDR_BITS:0]     rom_addr,
    output sto_pkg::sto_ctl_t                 ctl
);

    localparam int STEP_FULL_W = sto_pkg::STEP_W + 1;

    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [PHASE_BITS-1:0]      step_scaled;
    logic [STEP_FULL_W-1:0]     step_full;
    logic [1:0]                 quadrant;
    logic [TABLE_ADDR_BITS-1:0] idx;

    assign step_full = {1'b0, phase_step};

    // Step is in units of 2^-32 turn: align it to the accumulator width
    generate
        if (PHASE_BITS >= STEP_FULL_W) begin : g_step_up
            assign step_scaled = PHASE_BITS'(step_full) << (PHASE_BITS - STEP_FULL_W);
        end else begin : g_step_down
            assign step_scaled = PHASE_BITS'(step_full >> (STEP_FULL_W - PHASE_BITS));
        end
    endgenerate

    assign quadrant = phase_reg[PHASE_BITS-1 -: 2];
    assign idx      = phase_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    // Odd quadrants read the table mirrored
    assign rom_addr = quadrant[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, idx})
                                  : {1'b0, idx};

    assign ctl.mute = ~enable;
    assign ctl.neg  = quadrant[1];
    assign ctl.last = end_of_buffer;

    assign phase_next = phase_reg + step_scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (accept && enable)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sto_rom.sv
// Quarter-wave sine table with registered read.
`default_nettype none

module sto_rom #(
    parameter int TABLE_ADDR_BITS = sto_pkg::TABLE_ADDR_BITS_DEF,
    parameter int AMPLITUDE       = sto_pkg::AMPLITUDE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic [TABLE_ADDR_BITS:0]    addr,
    output logic      [sto_pkg::MAG_W-1:0]   rd_data
);

    localparam int DEPTH = (1 << TABLE_ADDR_BITS) + 1;

    typedef logic [sto_pkg::MAG_W-1:0] rom_arr_t [DEPTH];

    function automatic rom_arr_t build_rom();
        rom_arr_t r;
        int       k;
        for (k = 0; k < DEPTH; k++)
            r[k] = sto_pkg::quarter_sine(k, TABLE_ADDR_BITS, AMPLITUDE);
        return r;
    endfunction

    localparam rom_arr_t ROM = build_rom();

    logic [sto_pkg::MAG_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ROM[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/sto_out.sv
// Sign and mute stage, output register and pipeline flow control.
`default_nettype none

module sto_out (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire sto_pkg::sto_ctl_t                  ctl,
    input  wire logic        [sto_pkg::MAG_W-1:0]   mag,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed      [sto_pkg::SAMPLE_W-1:0] sample,
    output logic                                    last
);

    logic                                   s1_valid_reg;
    logic                                   s1_valid_next;
    sto_pkg::sto_ctl_t                      s1_ctl_reg;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic signed [sto_pkg::SAMPLE_W-1:0]    sample_reg;
    logic signed [sto_pkg::SAMPLE_W-1:0]    sample_next;
    logic                                   last_reg;
    logic signed [sto_pkg::SAMPLE_W-1:0]    mag_s;
    logic                                   out_free;
    logic                                   accept;

    assign out_free = ~out_valid_reg | out_ready;
    assign in_ready = ~s1_valid_reg | out_free;
    assign accept   = in_valid & in_ready;

    assign s1_valid_next  = accept ? 1'b1 : (out_free ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    assign mag_s = signed'({1'b0, mag});

    always_comb
    begin
        if (s1_ctl_reg.mute)
            sample_next = '0;
        else if (s1_ctl_reg.neg)
            sample_next = -mag_s;
        else
            sample_next = mag_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold while the stage ahead is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl;
        end
        if (out_free && s1_valid_reg)
        begin
            sample_reg <= sample_next;
            last_reg   <= s1_ctl_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

FILE: src/sine_tone_oscillator_core.sv
// Top level of the direct digital synthesis sine tone oscillator.
//
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------------------
//  s_*     | s_tvalid s_tready s_tdata[7:0]           | frame request in
//  m_*     | m_tvalid m_tready m_tdata[31:0] m_tlast  | stereo PCM frame out
//  cfg_*   | cfg_valid cfg_ready cfg_index cfg_data   | register write (always ready)
//
// One frame per cycle sustained while m_tready stays high; a taken request passes through
// the registered table read and then the output register before its frame appears.
// rst_n clears the phase, the registers and the pipeline valids at once.
// With m_tready low the output holds; s_tready drops only once both stages are full.
`default_nettype none

module sine_tone_oscillator_core #(
    parameter int PHASE_BITS      = sto_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = sto_pkg::TABLE_ADDR_BITS_DEF,
    parameter int AMPLITUDE       = sto_pkg::AMPLITUDE_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sto_pkg::IN_DATA_W-1:0]     s_tdata,   // [0] end_of_buffer
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sto_pkg::OUT_DATA_W-1:0]    m_tdata,   // [15:0] left, [31:16] right
    output logic                                   m_tlast,   // buffer_end
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sto_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sto_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                                   enable_reg;
    logic [sto_pkg::STEP_W-1:0]             phase_step_reg;
    logic                                   accept;
    logic [TABLE_ADDR_BITS:0]               rom_addr;
    sto_pkg::sto_ctl_t                      ctl;
    logic [sto_pkg::MAG_W-1:0]              mag;
    logic signed [sto_pkg::SAMPLE_W-1:0]    sample;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            phase_step_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Keep the low bits of the write; drop writes to unknown indexes
            unique case (sto_pkg::cfg_reg_t'(cfg_index))
                sto_pkg::CFG_ENABLE:     enable_reg     <= cfg_data[0];
                sto_pkg::CFG_PHASE_STEP: phase_step_reg <= cfg_data[sto_pkg::STEP_W-1:0];
                default:                 ;
            endcase
        end
    end

    sto_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .enable        (enable_reg),
        .phase_step    (phase_step_reg),
        .end_of_buffer (s_tdata[0]),
        .rom_addr      (rom_addr),
        .ctl           (ctl)
    );

    sto_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .AMPLITUDE       (AMPLITUDE)
    ) u_rom (
        .clk     (clk),
        .rd_en   (accept),
        .addr    (rom_addr),
        .rd_data (mag)
    );

    sto_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .ctl       (ctl),
        .mag       (mag),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sample    (sample),
        .last      (m_tlast)
    );

    assign m_tdata = {sample, sample};

`ifndef SYNTHESIS
    // An empty output slot must never block a request
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request blocked with an empty output slot");

    // The negative full-scale code never appears
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[sto_pkg::SAMPLE_W-1:0] != 16'h8000))
        else $error("sample outside the symmetric range");

    // A request taken into an empty pipeline with a free output shows up through the table read and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !m_tvalid) ##1 m_tready |=> m_tvalid)
        else $error("frame missing after its request");
`endif

endmodule

`default_nettype wire
